FILE: design/xmodem_receiver_engine_unit_assert.svh
// ----------------------------------------------------------------------------
// XMODEM receiver engine assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef XMODEM_RECEIVER_ENGINE_UNIT_ASSERT_SVH
`define XMODEM_RECEIVER_ENGINE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define XRE_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define XRE_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define XRE_ASSERT_IMP(lbl, a, b)
`define XRE_ASSERT_NXT(lbl, a, b)
`endif
`endif

FILE: design/xre_pkg.sv
// ----------------------------------------------------------------------------
// XMODEM receiver engine package
// Types, line byte codes and helpers shared by the engine files.
// ----------------------------------------------------------------------------
package xre_pkg;

  localparam int MAX_BLOCK_BYTES_DEF = 1024;

  localparam logic [7:0] B_SOH = 8'h01;
  localparam logic [7:0] B_STX = 8'h02;
  localparam logic [7:0] B_EOT = 8'h04;
  localparam logic [7:0] B_ACK = 8'h06;
  localparam logic [7:0] B_NAK = 8'h15;
  localparam logic [7:0] B_CAN = 8'h18;
  localparam logic [7:0] B_G   = 8'h47;
  localparam logic [7:0] B_C   = 8'h43;

  localparam logic [4:0] TRIES_PER_MODE = 5'd16;
  localparam logic [10:0] SOH_BYTES = 11'd128;
  localparam logic [10:0] STX_BYTES = 11'd1024;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_CMD   = 3'd1,
    PH_CAN2  = 3'd2,
    PH_RECV  = 3'd3,
    PH_FLUSH = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_CANCEL  = 3'd1,
    ACT_SYNC    = 3'd2,
    ACT_RETRIES = 3'd3,
    ACT_REJECT  = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    EV_BYTE    = 2'd0,
    EV_TIMEOUT = 2'd1,
    EV_START   = 2'd2
  } event_t;

  typedef enum logic [2:0] {
    REG_REQUEST_MODE = 3'd0,
    REG_ENABLE_1K    = 3'd1,
    REG_CONTROL_MODE = 3'd2,
    REG_DEST_SIZE    = 3'd3,
    REG_MAX_RETRANS  = 3'd4
  } reg_idx_t;

  localparam logic [1:0] KIND_SEND    = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;
  localparam logic [1:0] KIND_FINISH  = 2'd3;

  localparam logic [1:0] VERD_NEW    = 2'd0;
  localparam logic [1:0] VERD_DUP    = 2'd1;
  localparam logic [1:0] VERD_REJECT = 2'd2;

  localparam logic [2:0] ST_EOT     = 3'd0;
  localparam logic [2:0] ST_CONTROL = 3'd1;
  localparam logic [2:0] ST_CANCEL  = 3'd2;
  localparam logic [2:0] ST_SYNC    = 3'd3;
  localparam logic [2:0] ST_RETRIES = 3'd4;

  localparam logic [1:0] WAIT_REQUEST = 2'd0;
  localparam logic [1:0] WAIT_PACKET  = 2'd1;
  localparam logic [1:0] WAIT_FLUSH   = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [1:0]  verdict;
    logic [10:0] commit_count;
    logic [2:0]  status;
  } res_t;

  function automatic res_t mk_res(logic [1:0] kind, logic [7:0] b, logic [1:0] verd,
                                  logic [10:0] keep, logic [2:0] stat);
    res_t r;
    r.kind = kind;
    r.out_byte = b;
    r.verdict = verd;
    r.commit_count = keep;
    r.status = stat;
    return r;
  endfunction

  function automatic logic [7:0] req_byte(logic [1:0] rcs);
    logic [7:0] b;
    case (rcs)
      2'd1: b = B_NAK;
      2'd2: b = B_C;
      2'd3: b = B_G;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [15:0] crc_add(logic [15:0] acc, logic [7:0] v);
    logic [15:0] a;
    a = acc ^ {v, 8'h00};
    for (int k = 0; k < 8; k++) begin
      a = a[15] ? ((a << 1) ^ 16'h1021) : (a << 1);
    end
    return a;
  endfunction

endpackage

FILE: design/xre_if.sv
// ----------------------------------------------------------------------------
// XMODEM receiver engine channels
// Event input channel and result output channel.
// ----------------------------------------------------------------------------
interface xre_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] rx_byte;
  modport source (output valid, mode, rx_byte, input ready);
  modport sink (input valid, mode, rx_byte, output ready);
endinterface

interface xre_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [1:0]  verdict;
  logic [10:0] commit_count;
  logic [2:0]  status;
  logic [31:0] received_total;
  logic [1:0]  next_wait;
  logic        last;
  modport source (output valid, kind, out_byte, verdict, commit_count, status,
                  received_total, next_wait, last, input ready);
  modport sink (input valid, kind, out_byte, verdict, commit_count, status,
                received_total, next_wait, last, output ready);
endinterface

FILE: design/xmodem_receiver_engine_unit.sv
// ----------------------------------------------------------------------------
// XMODEM receiver engine
// Receiver side of XMODEM, XMODEM-1K and YMODEM-G, one event per transaction.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_ch   | in  | mode, rx_byte
//  out_ch  | out | kind, out_byte, verdict, commit_count, status,
//          |     | received_total, next_wait, last
//  cfg_*   | in  | cfg_we, cfg_idx, cfg_wdata
//
//  An event is processed in the cycle it is accepted; its 0 to 4 results are
//  held in a result buffer and leave one per cycle while the output is ready.
//  A new event is accepted while the last result of the previous one leaves,
//  so single-result events flow at one per cycle while the output is ready;
//  an event with more results holds the input until all but its last have left.
//  Synchronous active-low reset returns all state but the result buffer to its reset values.
//  Output stalls hold the buffer and block the input whenever a result is
//  waiting and does not leave in the same cycle.
// ----------------------------------------------------------------------------
`include "xmodem_receiver_engine_unit_assert.svh"

module xmodem_receiver_engine_unit
  import xre_pkg::*;
#(
  parameter int MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  xre_in_if.sink      in_ch,
  xre_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_wdata
);

  localparam bit StxOk = (MAX_BLOCK_BYTES >= 1024);

  logic [1:0]  req_mode_r;
  logic        en_1k_r;
  logic        ctrl_mode_r;
  logic [31:0] dest_size_r;
  logic [7:0]  max_retrans_r;

  phase_t      phase_r, ph;
  logic [1:0]  rcs_r, rcs;
  logic [1:0]  chk_r, chk;
  logic [4:0]  rty_r, rty;
  logic [8:0]  rl_r, rl;
  logic [7:0]  eb_r, eb;
  logic [10:0] bi_r, bi;
  logic        big_r, big;
  logic [7:0]  hn_r, hn;
  logic [7:0]  hc_r, hc;
  logic [15:0] crc_r, crc;
  logic [7:0]  sum_r, sum;
  logic [15:0] rc_r, rc;
  logic [31:0] tot_r, tot;
  action_t     afa_r, afa;

  res_t        rv [4];
  res_t        res_r [4];
  logic [2:0]  n;
  logic [2:0]  cnt_r;
  logic [1:0]  rd_r;
  logic [1:0]  wait_r, wt;

  logic        in_fire, out_fire;

  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_ch.ready = rst_n && ((cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_ch.ready));
  assign in_fire = in_ch.valid && in_ch.ready;

  always_comb begin
    logic        do_try;
    logic        do_block_end;
    logic [10:0] size;
    logic        uses_crc;
    logic [10:0] idx;
    logic [11:0] total;
    logic        hdr_ok, is_new, is_dup, sum_ok;
    logic [31:0] room;
    logic [10:0] keep;
    action_t     act;
    ph = phase_r; rcs = rcs_r; chk = chk_r; rty = rty_r; rl = rl_r; eb = eb_r;
    bi = bi_r; big = big_r; hn = hn_r; hc = hc_r; crc = crc_r; sum = sum_r;
    rc = rc_r; tot = tot_r; afa = afa_r;
    n = 3'd0;
    for (int i = 0; i < 4; i++) rv[i] = '0;
    do_try = 1'b0;
    do_block_end = 1'b0;
    size = big_r ? STX_BYTES : SOH_BYTES;
    uses_crc = (chk_r != 2'd0);
    idx = bi_r;
    total = {1'b0, size} + (uses_crc ? 12'd4 : 12'd3);
    hdr_ok = 1'b0; is_new = 1'b0; is_dup = 1'b0; sum_ok = 1'b0;
    room = '0; keep = '0; act = ACT_NONE;

    if (in_ch.mode == EV_START) begin
      case (req_mode_r)
        2'd0: begin rcs = 2'd1; chk = 2'd0; end
        2'd2: begin rcs = 2'd3; chk = 2'd2; end
        default: begin rcs = 2'd2; chk = 2'd1; end
      endcase
      rl = {1'b0, max_retrans_r};
      eb = ctrl_mode_r ? 8'd0 : 8'd1;
      tot = '0;
      afa = ACT_NONE;
      bi = '0; big = 1'b0; hn = '0; hc = '0; crc = '0; sum = '0; rc = '0;
      rty = '0;
      ph = PH_CMD;
      rv[n[1:0]] = mk_res(KIND_SEND, req_byte(rcs), '0, '0, '0); n = n + 3'd1;
    end else if (in_ch.mode != 2'd3) begin
      case (phase_r)
        PH_CMD: begin
          if (in_ch.mode == EV_TIMEOUT) do_try = 1'b1;
          else if (in_ch.rx_byte == B_SOH ||
                   (in_ch.rx_byte == B_STX && en_1k_r && StxOk)) begin
            bi = '0; hn = '0; hc = '0; crc = '0; sum = '0; rc = '0;
            big = (in_ch.rx_byte == B_STX);
            rcs = 2'd0;
            ph = PH_RECV;
          end else if (in_ch.rx_byte == B_EOT) begin
            rv[n[1:0]] = mk_res(KIND_SEND, B_ACK, '0, '0, '0); n = n + 3'd1;
            rv[n[1:0]] = mk_res(KIND_FINISH, '0, '0, '0, ST_EOT); n = n + 3'd1;
            ph = PH_IDLE;
          end else if (in_ch.rx_byte == B_CAN) ph = PH_CAN2;
          else do_try = 1'b1;
        end
        PH_CAN2: begin
          if (in_ch.mode == EV_BYTE && in_ch.rx_byte == B_CAN) begin
            ph = PH_FLUSH; afa = ACT_CANCEL;
          end else do_try = 1'b1;
        end
        PH_RECV: begin
          if (in_ch.mode == EV_TIMEOUT) begin
            rv[n[1:0]] = mk_res(KIND_VERDICT, '0, VERD_REJECT, '0, '0); n = n + 3'd1;
            ph = PH_FLUSH; afa = ACT_REJECT;
          end else begin
            if (idx == 11'd0) hn = in_ch.rx_byte;
            else if (idx == 11'd1) hc = in_ch.rx_byte;
            else if ({1'b0, idx} < {1'b0, size} + 12'd2) begin
              rv[n[1:0]] = mk_res(KIND_PAYLOAD, in_ch.rx_byte, '0, '0, '0);
              n = n + 3'd1;
              crc = crc_add(crc_r, in_ch.rx_byte);
              sum = sum_r + in_ch.rx_byte;
            end else if (uses_crc && ({1'b0, idx} == {1'b0, size} + 12'd2))
              rc = {in_ch.rx_byte, 8'h00};
            else if (uses_crc) rc = rc_r | {8'h00, in_ch.rx_byte};
            else rc = {8'h00, in_ch.rx_byte};
            bi = idx + 11'd1;
            do_block_end = ({1'b0, bi} >= total);
          end
        end
        PH_FLUSH: begin
          if (in_ch.mode == EV_TIMEOUT) begin
            act = afa_r;
            afa = ACT_NONE;
            if (act == ACT_CANCEL) begin
              rv[n[1:0]] = mk_res(KIND_SEND, B_ACK, '0, '0, '0); n = n + 3'd1;
              rv[n[1:0]] = mk_res(KIND_FINISH, '0, '0, '0, ST_CANCEL); n = n + 3'd1;
              ph = PH_IDLE;
            end else if (act == ACT_SYNC || act == ACT_RETRIES) begin
              rv[0] = mk_res(KIND_SEND, B_CAN, '0, '0, '0);
              rv[1] = mk_res(KIND_SEND, B_CAN, '0, '0, '0);
              rv[2] = mk_res(KIND_SEND, B_CAN, '0, '0, '0);
              rv[3] = mk_res(KIND_FINISH, '0, '0, '0,
                             (act == ACT_SYNC) ? ST_SYNC : ST_RETRIES);
              n = 3'd4;
              ph = PH_IDLE;
            end else begin
              rv[n[1:0]] = mk_res(KIND_SEND, B_NAK, '0, '0, '0); n = n + 3'd1;
              rty = '0;
              ph = PH_CMD;
            end
          end
        end
        PH_IDLE: ;
        default: ph = PH_IDLE;
      endcase

      if (do_try) begin
        rty = rty_r + 5'd1;
        if (rty < TRIES_PER_MODE) begin
          ph = PH_CMD;
          if (rcs != 2'd0) begin
            rv[n[1:0]] = mk_res(KIND_SEND, req_byte(rcs), '0, '0, '0); n = n + 3'd1;
          end
        end else if (rcs == 2'd3 || rcs == 2'd2) begin
          rcs = rcs - 2'd1;
          chk = (rcs == 2'd2) ? 2'd1 : 2'd0;
          rty = '0;
          ph = PH_CMD;
          rv[n[1:0]] = mk_res(KIND_SEND, req_byte(rcs), '0, '0, '0); n = n + 3'd1;
        end else begin
          ph = PH_FLUSH; afa = ACT_SYNC;
        end
      end

      if (do_block_end) begin
        hdr_ok = (hn == ~hc);
        is_new = (hn == eb_r);
        is_dup = (hn == eb_r - 8'd1);
        sum_ok = uses_crc ? (crc == rc) : (sum == rc[7:0]);
        if (!(hdr_ok && (is_new || is_dup) && sum_ok)) begin
          rv[n[1:0]] = mk_res(KIND_VERDICT, '0, VERD_REJECT, '0, '0); n = n + 3'd1;
          ph = PH_FLUSH; afa = ACT_REJECT;
        end else begin
          if (is_new) begin
            if (tot_r < dest_size_r) begin
              room = dest_size_r - tot_r;
              keep = (room < {21'd0, size}) ? room[10:0] : size;
              tot = tot_r + {21'd0, keep};
            end
            eb = eb_r + 8'd1;
            rl = {1'b0, max_retrans_r} + 9'd1;
          end
          rv[n[1:0]] = mk_res(KIND_VERDICT, '0, is_new ? VERD_NEW : VERD_DUP, keep, '0);
          n = n + 3'd1;
          if (rl <= 9'd1) begin
            rl = '0;
            ph = PH_FLUSH; afa = ACT_RETRIES;
          end else begin
            rl = rl - 9'd1;
            if (chk != 2'd2) begin
              rv[n[1:0]] = mk_res(KIND_SEND, B_ACK, '0, '0, '0); n = n + 3'd1;
            end
            if (ctrl_mode_r) begin
              rv[n[1:0]] = mk_res(KIND_FINISH, '0, '0, '0, ST_CONTROL); n = n + 3'd1;
              ph = PH_IDLE;
            end else begin
              rty = '0;
              ph = PH_CMD;
            end
          end
        end
      end
    end

    if (ph == PH_FLUSH) wt = WAIT_FLUSH;
    else if (ph == PH_CAN2 || ph == PH_RECV) wt = WAIT_PACKET;
    else wt = WAIT_REQUEST;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_mode_r    <= 2'd1;
      en_1k_r       <= 1'b1;
      ctrl_mode_r   <= 1'b0;
      dest_size_r   <= 32'hFFFF_FFFF;
      max_retrans_r <= 8'd25;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_REQUEST_MODE: req_mode_r    <= cfg_wdata[1:0];
        REG_ENABLE_1K:    en_1k_r       <= cfg_wdata[0];
        REG_CONTROL_MODE: ctrl_mode_r   <= cfg_wdata[0];
        REG_DEST_SIZE:    dest_size_r   <= cfg_wdata;
        REG_MAX_RETRANS:  max_retrans_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      rcs_r <= 2'd2; chk_r <= 2'd1; rty_r <= '0; rl_r <= 9'd25; eb_r <= 8'd1;
      bi_r <= '0; big_r <= 1'b0; hn_r <= '0; hc_r <= '0; crc_r <= '0;
      sum_r <= '0; rc_r <= '0; tot_r <= '0; afa_r <= ACT_NONE;
      cnt_r <= '0; rd_r <= '0; wait_r <= WAIT_REQUEST;
    end else if (in_fire) begin
      phase_r <= ph; rcs_r <= rcs; chk_r <= chk; rty_r <= rty; rl_r <= rl;
      eb_r <= eb; bi_r <= bi; big_r <= big; hn_r <= hn; hc_r <= hc;
      crc_r <= crc; sum_r <= sum; rc_r <= rc; tot_r <= tot; afa_r <= afa;
      cnt_r <= n; rd_r <= '0; wait_r <= wt;
    end else if (out_fire) begin
      cnt_r <= cnt_r - 3'd1;
      rd_r <= rd_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < 4; i++) res_r[i] <= rv[i];
    end
  end

  assign out_ch.valid          = (cnt_r != 3'd0);
  assign out_ch.kind           = res_r[rd_r].kind;
  assign out_ch.out_byte       = res_r[rd_r].out_byte;
  assign out_ch.verdict        = res_r[rd_r].verdict;
  assign out_ch.commit_count   = res_r[rd_r].commit_count;
  assign out_ch.status         = res_r[rd_r].status;
  assign out_ch.received_total = tot_r;
  assign out_ch.next_wait      = wait_r;
  assign out_ch.last           = (cnt_r == 3'd1);

  `XRE_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= 3'd4)
  `XRE_ASSERT_IMP(a_accept_drained, in_fire, cnt_r <= 3'd1)
  `XRE_ASSERT_NXT(a_drain_last, out_fire && cnt_r == 3'd1 && !in_fire, cnt_r == 3'd0)
  `XRE_ASSERT_IMP(a_flush_wait, phase_r == PH_FLUSH, wait_r == WAIT_FLUSH)

endmodule
